// File: hdl/ssb_pkg.sv
// Package for the sprite sort and texture batcher.
// Holds shared constants, the controller state type and the command/status structs.
// No dependencies.
package ssb_pkg;

    localparam int MAX_SPRITES_DEF  = 64;
    localparam int TEXTURE_BITS_DEF = 16;
    localparam int VERTS_PER_SPRITE = 6;

    localparam logic [1:0] ORDER_ARRIVAL   = 2'd0;
    localparam logic [1:0] ORDER_DEPTH_ASC = 2'd1;
    localparam logic [1:0] ORDER_DEPTH_DSC = 2'd2;
    localparam logic [1:0] ORDER_TEX_ASC   = 2'd3;

    localparam logic [0:0] MODE_ADD = 1'b0;
    localparam logic [0:0] MODE_END = 1'b1;

    localparam logic [0:0] REG_SORT_ORDER = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_READ,
        ST_KEY_LOAD,
        ST_SHIFT,
        ST_EMIT
    } ssb_state_t;

    typedef struct packed {
        logic store;
        logic drop;
        logic clear;
        logic sort_init;
        logic key_read;
        logic key_load;
        logic shift;
        logic place;
        logic emit_init;
        logic emit_read;
    } ssb_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic sort_done;
        logic ins_busy;
        logic emit_last;
    } ssb_status_t;

endpackage

// File: hdl/ssb_ctrl.sv
// Controller state machine of the sprite sort and texture batcher.
// Depends on ssb_pkg.
module ssb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 add_go,
    input  logic                 end_go,
    input  ssb_pkg::ssb_status_t status,
    output ssb_pkg::ssb_cmd_t    cmd,
    output logic                 busy
);
    import ssb_pkg::*;

    ssb_state_t state_reg;
    ssb_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (add_go)
                begin
                    if (status.full)
                    begin
                        cmd.drop = 1'b1;
                    end
                    else
                    begin
                        cmd.store = 1'b1;
                    end
                end
                else if (end_go)
                begin
                    if (status.empty)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_KEY_READ;
                    end
                end
            end
            ST_KEY_READ:
            begin
                if (status.sort_done)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    cmd.key_read = 1'b1;
                    state_next   = ST_KEY_LOAD;
                end
            end
            ST_KEY_LOAD:
            begin
                cmd.key_load = 1'b1;
                state_next   = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                // Each cycle moves one entry up until the key finds its slot.
                if (status.ins_busy)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    cmd.place  = 1'b1;
                    state_next = ST_KEY_READ;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_read = 1'b1;
                if (status.emit_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/ssb_datapath.sv
// Datapath of the sprite sort and texture batcher: sprite record store, in-place
// insertion sort with one registered read a cycle, and result formatting. Depends on ssb_pkg.
module ssb_datapath
#(
    parameter int MAX_SPRITES  = ssb_pkg::MAX_SPRITES_DEF,
    parameter int TEXTURE_BITS = ssb_pkg::TEXTURE_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ssb_pkg::ssb_cmd_t    cmd,
    output ssb_pkg::ssb_status_t status,
    input  logic [1:0]           sort_order,
    input  logic signed [15:0]   sprite_depth,
    input  logic [15:0]          texture_id,
    output logic                 result_valid,
    output logic [5:0]           arrival_index,
    output logic [15:0]          texture_out,
    output logic [8:0]           vertex_offset,
    output logic                 starts_batch,
    output logic                 overflowed,
    output logic                 last
);
    import ssb_pkg::*;

    localparam int IW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);

    typedef struct packed {
        logic [IW-1:0]           idx;
        logic signed [15:0]      depth;
        logic [TEXTURE_BITS-1:0] tex;
    } sprite_rec_t;

    // Sprite records, in arrival order until an end item sorts them in place.
    sprite_rec_t             rec_mem [MAX_SPRITES];
    sprite_rec_t             rd_reg;
    sprite_rec_t             key_reg;

    logic [CW-1:0]           count_reg, count_next;
    logic                    ovf_reg, ovf_next;
    logic [CW-1:0]           pass_reg;      // record being inserted
    logic [CW-1:0]           hole_reg;      // slot the key would take
    logic [CW-1:0]           emit_reg;
    logic [8:0]              vtx_reg;
    logic [8:0]              vtx_out_reg;
    logic                    first_reg;
    logic                    last_reg;
    logic                    ovf_out_reg;
    logic [TEXTURE_BITS-1:0] prev_tex_reg;

    sprite_rec_t             new_rec;
    sprite_rec_t             wr_data;
    logic                    wr_en;
    logic [IW-1:0]           wr_addr;
    logic [IW-1:0]           rd_addr;
    logic [CW-1:0]           pass_m1;
    logic [CW-1:0]           hole_m1;
    logic [CW-1:0]           hole_m2;
    logic [CW-1:0]           count_m1;
    logic                    key_before;

    assign new_rec  = {count_reg[IW-1:0], sprite_depth, TEXTURE_BITS'(texture_id)};
    assign pass_m1  = pass_reg - CW'(1);
    assign hole_m1  = hole_reg - CW'(1);
    assign hole_m2  = hole_reg - CW'(2);
    assign count_m1 = count_reg - CW'(1);

    // The key goes ahead of the record just read only on a strict order.
    always_comb
    begin
        case (sort_order)
            ORDER_DEPTH_ASC: key_before = $signed(key_reg.depth) < $signed(rd_reg.depth);
            ORDER_DEPTH_DSC: key_before = $signed(key_reg.depth) > $signed(rd_reg.depth);
            ORDER_TEX_ASC:   key_before = key_reg.tex < rd_reg.tex;
            default:         key_before = 1'b0;
        endcase
    end

    assign status.full      = (count_reg == CW'(MAX_SPRITES));
    assign status.empty     = (count_reg == '0);
    assign status.sort_done = (pass_reg == count_reg);
    assign status.ins_busy  = (hole_reg != '0) && key_before;
    assign status.emit_last = (emit_reg == count_m1);

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hole_reg[IW-1:0];
        wr_data = key_reg;
        if (cmd.store)
        begin
            wr_en   = 1'b1;
            wr_addr = count_reg[IW-1:0];
            wr_data = new_rec;
        end
        else if (cmd.shift)
        begin
            wr_en   = 1'b1;
            wr_data = rd_reg;
        end
        else if (cmd.place)
        begin
            wr_en   = 1'b1;
        end
    end

    always_comb
    begin
        rd_addr = emit_reg[IW-1:0];
        if (cmd.key_read)
        begin
            rd_addr = pass_reg[IW-1:0];
        end
        else if (cmd.key_load)
        begin
            rd_addr = pass_m1[IW-1:0];
        end
        else if (cmd.shift)
        begin
            rd_addr = hole_m2[IW-1:0];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.store)
        begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.drop)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            result_valid <= cmd.emit_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_addr] <= wr_data;
        end
        rd_reg <= rec_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_init)
        begin
            pass_reg <= CW'(1);
        end
        else if (cmd.place)
        begin
            pass_reg <= pass_reg + CW'(1);
        end
        if (cmd.key_load)
        begin
            key_reg  <= rd_reg;
            hole_reg <= pass_reg;
        end
        else if (cmd.shift)
        begin
            hole_reg <= hole_m1;
        end
        if (cmd.emit_init)
        begin
            emit_reg <= '0;
            vtx_reg  <= '0;
        end
        else if (cmd.emit_read)
        begin
            emit_reg    <= emit_reg + CW'(1);
            vtx_reg     <= vtx_reg + 9'(VERTS_PER_SPRITE);
            vtx_out_reg <= vtx_reg;
            first_reg   <= (emit_reg == '0);
            last_reg    <= status.emit_last;
            ovf_out_reg <= ovf_reg;
        end
        if (result_valid)
        begin
            prev_tex_reg <= rd_reg.tex;
        end
    end

    // The read register holds the record of the result on the ports.
    assign arrival_index = 6'(rd_reg.idx);
    assign texture_out   = 16'(rd_reg.tex);
    assign vertex_offset = vtx_out_reg;
    assign starts_batch  = first_reg || (rd_reg.tex != prev_tex_reg);
    assign overflowed    = ovf_out_reg;
    assign last          = last_reg;

endmodule

// File: hdl/sprite_sort_and_texture_batcher_top.sv
// Top level of the sprite sort and texture batcher.
// Instantiates ssb_ctrl and ssb_datapath; depends on ssb_pkg.
//
// Usage: items are offered on start with mode 0 (add) or mode 1 (end) and are
// taken at a clock edge where start is high and busy is low.
// An add item stores one sprite and busy stays low, so adds can follow back
// to back. An add that finds MAX_SPRITES sprites stored is dropped
// and flags overflow on the results of the next end item.
// An end item with n stored sprites raises busy and first sorts the store in
// place by the sort_order register with a stable insertion sort: each sprite
// after the first is read, loaded as the key, shifted past the earlier sprites
// it goes ahead of and placed. One result per cycle then follows in sorted
// order, each marked by result_valid for one cycle. The total of moves past
// earlier sprites is at most n(n-1)/2, and the last result is on the ports in
// the cycle in which busy falls. An end on an empty store gives no results and
// clears the overflow flag. The store is emptied after every end item.
// The receiver cannot stall; results must be taken as they appear.
// Reset empties the store, clears the overflow flag and sets sort_order to
// arrival order. sort_order is written over the APB port; the user must write
// it only while busy is low, as the block does not enforce it.
module sprite_sort_and_texture_batcher_top
#(
    parameter int MAX_SPRITES  = ssb_pkg::MAX_SPRITES_DEF,
    parameter int TEXTURE_BITS = ssb_pkg::TEXTURE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic signed [15:0] sprite_depth,
    input  logic [15:0]        texture_id,
    output logic               result_valid,
    output logic [5:0]         arrival_index,
    output logic [15:0]        texture_out,
    output logic [8:0]         vertex_offset,
    output logic               starts_batch,
    output logic               overflowed,
    output logic               last
);
    import ssb_pkg::*;

    logic [1:0]  sort_order_reg;
    ssb_cmd_t    cmd;
    ssb_status_t status;
    logic        accept;
    logic        add_go;
    logic        end_go;

    assign pready = 1'b1;
    // Only register 0 exists; the single word address bit selects it.
    assign prdata = (paddr[1] == REG_SORT_ORDER) ? {30'd0, sort_order_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_order_reg <= ORDER_ARRIVAL;
        end
        else if (psel && penable && pwrite && pready && (paddr[1] == REG_SORT_ORDER))
        begin
            sort_order_reg <= pwdata[1:0];
        end
    end

    assign accept = start && !busy;
    assign end_go = accept && (mode == MODE_END);
    // The controller drops an add, and only flags overflow, when the store is full.
    assign add_go = accept && (mode == MODE_ADD);

    ssb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .add_go (add_go),
        .end_go (end_go),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ssb_datapath
    #(
        .MAX_SPRITES  (MAX_SPRITES),
        .TEXTURE_BITS (TEXTURE_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .sort_order    (sort_order_reg),
        .sprite_depth  (sprite_depth),
        .texture_id    (texture_id),
        .result_valid  (result_valid),
        .arrival_index (arrival_index),
        .texture_out   (texture_out),
        .vertex_offset (vertex_offset),
        .starts_batch  (starts_batch),
        .overflowed    (overflowed),
        .last          (last)
    );

endmodule
